// ===== design/drd_pkg.sv =====
// Package for the drive run detector: sizes, mode codes and the command
// and status structs that join the controller and the datapath.
// Depends on nothing; every other design file imports it.
package drd_pkg;

    localparam int CHANNELS     = 8;
    localparam int WINDOW_DEPTH = 8;

    localparam int CH_W    = 3;
    localparam int TIME_W  = 32;
    localparam int VAL_W   = 16;
    localparam int PULSE_W = 32;
    localparam int ST_W    = 16;
    localparam int MODES_W = 16;
    localparam int CNT_W   = 2;

    localparam int CH_IW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int HEAD_W    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int FILL_W    = $clog2(WINDOW_DEPTH + 1);
    localparam int MEM_DEPTH = CHANNELS * WINDOW_DEPTH;
    localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    localparam logic [CNT_W-1:0]  CHANGE_LIMIT = 2'd3;
    localparam logic [TIME_W-1:0] START_DELAY  = 32'd2;

    localparam logic [1:0] MODE_DISABLED = 2'd0;
    localparam logic [1:0] MODE_ANALOG   = 2'd1;
    localparam logic [1:0] MODE_PULSE    = 2'd2;
    localparam logic [1:0] MODE_PASS     = 2'd3;

    typedef struct packed {
        logic load_in;
        logic eval;
        logic scan_issue;
        logic commit_max;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic push;
        logic scan_last;
        logic out_free;
    } t_status;

endpackage

// ===== design/drd_if.sv =====
// Request and response channel interfaces of the drive run detector.
// Depends on drd_pkg for the field widths.
interface drd_req_if import drd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CH_W-1:0]     channel;
    logic [TIME_W-1:0]   time_now;
    logic                drive_ready;
    logic [VAL_W-1:0]    drive_command;
    logic [VAL_W-1:0]    speed_sample;
    logic [PULSE_W-1:0]  pulse_count;
    logic [ST_W-1:0]     sample_time;

    modport source (output valid, channel, time_now, drive_ready, drive_command,
                    speed_sample, pulse_count, sample_time, input ready);
    modport sink   (input valid, channel, time_now, drive_ready, drive_command,
                    speed_sample, pulse_count, sample_time, output ready);
endinterface

interface drd_rsp_if import drd_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] out_channel;
    logic            run_enabled;
    logic            running;
    logic [VAL_W-1:0] encoder_value;

    modport source (output valid, out_channel, run_enabled, running, encoder_value,
                    input ready);
    modport sink   (input valid, out_channel, run_enabled, running, encoder_value,
                    output ready);
endinterface

// ===== design/drive_run_detector.sv =====
// Top level of the drive run detector: joins the sequencer and the datapath.
// Depends on drd_pkg, drd_req_if, drd_rsp_if, drd_ctrl and drd_dpath.
//
// Usage: each request on i_req is one control tick for one feeder drive
// channel. The block answers every request with exactly one response on
// o_rsp carrying the channel, whether it is enabled, its running flag and
// the held encoder value. Channel modes come from a 16-bit register written
// through i_cfg_we and i_cfg_wdata; the user must write it only while no
// request is in flight, which the block itself does not enforce.
//
// Sequence: a request is taken in the idle state and updated in the next
// cycle; its response is loaded into the output register from the done
// state once that register is free. An analog tick that pushes a new speed
// sample also scans the channel's window for its maximum through the single
// read port of the window memory, one entry per cycle, then commits the
// maximum in a drain step that covers the read latency.
//
// Reset (synchronous, active low) clears the mode register, every channel's
// flags, counters, time stamps and held values, and empties all windows.
// If the receiver stalls, the finished response waits in the output
// register; the block takes the next request and holds its finished result
// until the output register is free.
module drive_run_detector import drd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [MODES_W-1:0] i_cfg_wdata,
    drd_req_if.sink            i_req,
    drd_rsp_if.source          o_rsp
);

    t_cmd    w_cmd;
    t_status w_status;

    // Sequencer: owns the request handshake and the step order.
    drd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // Datapath: per-channel state, window memory and the response register.
    drd_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_channel       (i_req.channel),
        .i_time_now      (i_req.time_now),
        .i_drive_ready   (i_req.drive_ready),
        .i_drive_command (i_req.drive_command),
        .i_speed_sample  (i_req.speed_sample),
        .i_pulse_count   (i_req.pulse_count),
        .i_sample_time   (i_req.sample_time),
        .i_out_ready     (o_rsp.ready),
        .o_out_valid     (o_rsp.valid),
        .o_out_channel   (o_rsp.out_channel),
        .o_run_enabled   (o_rsp.run_enabled),
        .o_running       (o_rsp.running),
        .o_encoder_value (o_rsp.encoder_value)
    );

    // The sequencer issues at most one command in any cycle.
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.load_in, w_cmd.eval, w_cmd.scan_issue,
                  w_cmd.commit_max, w_cmd.load_out}))
        else $error("more than one datapath command in a cycle");

    // A response is never loaded over one that the receiver has not taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> (!o_rsp.valid || o_rsp.ready))
        else $error("response register overwritten while stalled");

    // An accepted request is always followed by its update step.
    a_accept_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (w_cmd.eval && !i_req.ready))
        else $error("accepted request not followed by its update");

    // A window scan ends with the maximum being committed.
    a_scan_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.scan_issue && w_status.scan_last) |=> w_cmd.commit_max)
        else $error("window scan did not commit its maximum");

endmodule

// ===== design/drd_ctrl.sv =====
// Sequencer of the drive run detector: accepts a request, steps the
// datapath through update, window scan and result hand-off. Uses drd_pkg.
module drd_ctrl import drd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_req_valid,
    output logic    o_req_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EVAL  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_status.push ? S_SCAN : S_DONE;
            end
            S_SCAN: begin
                o_cmd.scan_issue = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                o_cmd.commit_max = 1'b1;
                n_state          = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== design/drd_dpath.sv =====
// Datapath of the drive run detector: request registers, per-channel state,
// the speed window memory with its max scan, and the response register.
// Uses drd_pkg; driven by drd_ctrl through t_cmd and t_status.
module drd_dpath import drd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [MODES_W-1:0] i_cfg_wdata,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    input  logic [CH_W-1:0]    i_channel,
    input  logic [TIME_W-1:0]  i_time_now,
    input  logic               i_drive_ready,
    input  logic [VAL_W-1:0]   i_drive_command,
    input  logic [VAL_W-1:0]   i_speed_sample,
    input  logic [PULSE_W-1:0] i_pulse_count,
    input  logic [ST_W-1:0]    i_sample_time,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [CH_W-1:0]    o_out_channel,
    output logic               o_run_enabled,
    output logic               o_running,
    output logic [VAL_W-1:0]   o_encoder_value
);

    logic [MODES_W-1:0] r_modes;

    logic [CH_W-1:0]    r_ch;
    logic [TIME_W-1:0]  r_now;
    logic               r_ready;
    logic [VAL_W-1:0]   r_cmd;
    logic [VAL_W-1:0]   r_speed;
    logic [PULSE_W-1:0] r_pulses;
    logic [ST_W-1:0]    r_st;

    logic               r_run   [CHANNELS];
    logic [TIME_W-1:0]  r_stamp [CHANNELS];
    logic [CNT_W-1:0]   r_cnt   [CHANNELS];
    logic [PULSE_W-1:0] r_last  [CHANNELS];
    logic [FILL_W-1:0]  r_fill  [CHANNELS];
    logic [HEAD_W-1:0]  r_head  [CHANNELS];
    logic [VAL_W-1:0]   r_held  [CHANNELS];

    logic [VAL_W-1:0]   r_window [MEM_DEPTH];
    logic [VAL_W-1:0]   r_rd_data;
    logic               r_rd_vld;
    logic [FILL_W-1:0]  r_scan_i;
    logic [FILL_W-1:0]  r_scan_n;
    logic [VAL_W-1:0]   r_max;

    logic               r_out_valid;
    logic [CH_W-1:0]    r_out_ch;
    logic               r_out_en;
    logic               r_out_run;
    logic [VAL_W-1:0]   r_out_enc;

    logic               w_in_range;
    logic [CH_IW-1:0]   w_idx;
    logic [MODES_W-1:0] w_modes_sh;
    logic [1:0]         w_mode;
    logic               c_run;
    logic [TIME_W-1:0]  c_stamp;
    logic [CNT_W-1:0]   c_cnt;
    logic [PULSE_W-1:0] c_last;
    logic [FILL_W-1:0]  c_fill;
    logic [HEAD_W-1:0]  c_head;
    logic [TIME_W-1:0]  w_addend;
    logic [TIME_W-1:0]  w_due_time;
    logic               w_due;
    logic [CNT_W-1:0]   w_cnt_inc;
    logic [MEM_AW-1:0]  w_base;
    logic [VAL_W-1:0]   w_max;

    logic               n_run;
    logic [TIME_W-1:0]  n_stamp;
    logic [CNT_W-1:0]   n_cnt;
    logic [PULSE_W-1:0] n_last;
    logic [FILL_W-1:0]  n_fill;
    logic [HEAD_W-1:0]  n_head;
    logic [VAL_W-1:0]   n_held;
    logic               n_push;

    assign w_in_range = (32'(r_ch) < CHANNELS);
    assign w_idx      = CH_IW'(r_ch);
    assign w_modes_sh = r_modes >> {r_ch, 1'b0};
    assign w_mode     = w_modes_sh[1:0];

    assign c_run   = r_run[w_idx];
    assign c_stamp = r_stamp[w_idx];
    assign c_cnt   = r_cnt[w_idx];
    assign c_last  = r_last[w_idx];
    assign c_fill  = r_fill[w_idx];
    assign c_head  = r_head[w_idx];

    // Analog mode waits the start delay before the first window update.
    assign w_addend   = (w_mode == MODE_ANALOG && c_cnt == '0) ? START_DELAY
                                                               : TIME_W'(r_st);
    assign w_due_time = c_stamp + w_addend;
    assign w_due      = (r_now >= w_due_time);
    assign w_cnt_inc  = (c_cnt < CHANGE_LIMIT) ? c_cnt + CNT_W'(1) : c_cnt;
    assign w_base     = MEM_AW'(int'(w_idx) * WINDOW_DEPTH);

    always_comb begin
        n_run   = c_run;
        n_stamp = c_stamp;
        n_cnt   = c_cnt;
        n_last  = c_last;
        n_fill  = c_fill;
        n_head  = c_head;
        n_held  = r_held[w_idx];
        n_push  = 1'b0;
        unique case (w_mode)
            MODE_ANALOG: begin
                if (!r_ready) begin
                    if (c_run) begin
                        n_run   = 1'b0;
                        n_stamp = r_now;
                        n_held  = '0;
                        n_fill  = '0;
                        n_head  = '0;
                    end
                end else if (!c_run) begin
                    n_run   = 1'b1;
                    n_stamp = r_now;
                    n_cnt   = '0;
                end else if (w_due) begin
                    if (c_cnt == '0) begin
                        n_cnt = CNT_W'(1);
                    end
                    n_stamp = r_now;
                    n_push  = 1'b1;
                    n_head  = (c_head == HEAD_W'(WINDOW_DEPTH - 1)) ? '0
                                                                    : c_head + HEAD_W'(1);
                    n_fill  = (c_fill < FILL_W'(WINDOW_DEPTH)) ? c_fill + FILL_W'(1)
                                                               : c_fill;
                end
            end
            MODE_PULSE: begin
                if (!r_ready) begin
                    if (c_cnt != '0) begin
                        n_cnt   = '0;
                        n_run   = 1'b0;
                        n_stamp = r_now;
                        n_held  = '0;
                    end
                end else begin
                    if (r_pulses != c_last) begin
                        n_last  = r_pulses;
                        n_stamp = r_now;
                        n_cnt   = w_cnt_inc;
                        if (w_cnt_inc >= CHANGE_LIMIT) begin
                            n_run = 1'b1;
                        end
                    end else if (r_now < c_stamp) begin
                        // Clock rollover: restart the timeout.
                        n_stamp = r_now;
                    end else if (c_run && w_due) begin
                        n_run   = 1'b0;
                        n_cnt   = '0;
                        n_stamp = r_now;
                    end
                    n_held = n_run ? r_cmd : '0;
                end
            end
            default: begin
                n_run  = r_ready;
                n_held = r_cmd;
            end
        endcase
    end

    assign w_max = (r_rd_vld && r_rd_data > r_max) ? r_rd_data : r_max;

    assign o_status.push      = w_in_range && n_push;
    assign o_status.scan_last = (FILL_W'(r_scan_i + FILL_W'(1)) == r_scan_n);
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modes <= '0;
        end else if (i_cfg_we) begin
            r_modes <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_ch     <= i_channel;
            r_now    <= i_time_now;
            r_ready  <= i_drive_ready;
            r_cmd    <= i_drive_command;
            r_speed  <= i_speed_sample;
            r_pulses <= i_pulse_count;
            r_st     <= i_sample_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_run[c]   <= 1'b0;
                r_stamp[c] <= '0;
                r_cnt[c]   <= '0;
                r_last[c]  <= '0;
                r_fill[c]  <= '0;
                r_head[c]  <= '0;
                r_held[c]  <= '0;
            end
        end else begin
            if (i_cmd.eval && w_in_range) begin
                r_run[w_idx]   <= n_run;
                r_stamp[w_idx] <= n_stamp;
                r_cnt[w_idx]   <= n_cnt;
                r_last[w_idx]  <= n_last;
                r_fill[w_idx]  <= n_fill;
                r_head[w_idx]  <= n_head;
                r_held[w_idx]  <= n_held;
            end
            if (i_cmd.commit_max) begin
                r_held[w_idx] <= w_max;
            end
        end
    end

    // Window memory: one write port for the push, one registered read port
    // for the scan.
    always_ff @(posedge i_clk) begin
        if (i_cmd.eval && o_status.push) begin
            r_window[w_base + MEM_AW'(c_head)] <= r_speed;
        end
        r_rd_data <= r_window[w_base + MEM_AW'(r_scan_i)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_scan_i <= '0;
            r_scan_n <= '0;
            r_max    <= '0;
        end else begin
            r_rd_vld <= i_cmd.scan_issue;
            if (i_cmd.eval) begin
                r_scan_i <= '0;
                r_scan_n <= n_fill;
                r_max    <= '0;
            end else begin
                if (i_cmd.scan_issue) begin
                    r_scan_i <= r_scan_i + FILL_W'(1);
                end
                r_max <= w_max;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_ch  <= r_ch;
            r_out_en  <= w_in_range && (w_mode != MODE_DISABLED);
            r_out_run <= w_in_range ? r_run[w_idx] : r_ready;
            r_out_enc <= w_in_range ? r_held[w_idx] : r_cmd;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_channel   = r_out_ch;
    assign o_run_enabled   = r_out_en;
    assign o_running       = r_out_run;
    assign o_encoder_value = r_out_enc;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for drive_run_detector: directed and random control ticks.
// Depends on drd_pkg and the drd_req_if / drd_rsp_if interfaces from the design folder.
// Responses are compared, field by field, against a cycle-free predictor of the channel state.
module testbench;
    import drd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // The run is stopped as failed after this many clock cycles. A correct run of
    // roughly nine hundred requests needs fewer, even with every request
    // waiting out the longest sender gap and receiver stall.
    localparam int CYCLE_LIMIT = 500_000;

    // One control tick as the sender presents it.
    typedef struct {
        logic [CH_W-1:0]    channel;
        logic [TIME_W-1:0]  time_now;
        logic               drive_ready;
        logic [VAL_W-1:0]   drive_command;
        logic [VAL_W-1:0]   speed_sample;
        logic [PULSE_W-1:0] pulse_count;
        logic [ST_W-1:0]    sample_time;
    } t_tick;

    // One channel status as the block reports it.
    typedef struct {
        logic [CH_W-1:0]  out_channel;
        logic             run_enabled;
        logic             running;
        logic [VAL_W-1:0] encoder_value;
    } t_resp;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [MODES_W-1:0]  cfg_wdata = '0;

    drd_req_if req_bus ();
    drd_rsp_if rsp_bus ();

    drive_run_detector i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_bus),
        .o_rsp       (rsp_bus)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predicted channel state. Everything here mirrors what the block keeps
    // per channel, starting from the all-zero reset state. The speed history
    // itself is left unset since only entries below the fill count are read.
    // ------------------------------------------------------------------
    logic [MODES_W-1:0] modes_shadow = '0;
    logic               run_flag   [CHANNELS] = '{default: 1'b0};
    logic [TIME_W-1:0]  stamp      [CHANNELS] = '{default: '0};
    logic [CNT_W-1:0]   change_cnt [CHANNELS] = '{default: '0};
    logic [PULSE_W-1:0] last_pulse [CHANNELS] = '{default: '0};
    logic [VAL_W-1:0]   speed_hist [CHANNELS][WINDOW_DEPTH];
    logic [FILL_W-1:0]  hist_fill  [CHANNELS] = '{default: '0};
    logic [HEAD_W-1:0]  hist_head  [CHANNELS] = '{default: '0};
    logic [VAL_W-1:0]   held_value [CHANNELS] = '{default: '0};

    t_resp   expected_status_q [$];
    int      mismatches = 0;
    int      cycle_count = 0;

    // Stimulus state: a shared seconds clock and a per-channel pulse counter
    // that the random ticks advance so that well-formed runs actually occur.
    logic [TIME_W-1:0]  clock_secs = '0;
    logic [PULSE_W-1:0] pulse_feed [CHANNELS] = '{default: '0};

    // Idling controls: the sender idles between bursts, the receiver stalls on
    // a rotating bit pattern. Either can be switched off for a stretch.
    bit          sender_idles = 1'b0;
    bit          receiver_stalls = 1'b0;
    int          burst_left = 0;
    logic [31:0] stall_pattern = '1;
    logic [4:0]  stall_step = '0;

    // Push a speed sample into the channel's history and return the maximum
    // over the filled entries.
    function automatic logic [VAL_W-1:0] push_speed(input int ch, input logic [VAL_W-1:0] speed);
        logic [VAL_W-1:0] peak;
        peak = '0;
        speed_hist[ch][hist_head[ch]] = speed;
        hist_head[ch] = (hist_head[ch] == WINDOW_DEPTH - 1) ? '0 : hist_head[ch] + 1'b1;
        if (hist_fill[ch] < WINDOW_DEPTH)
            hist_fill[ch] = hist_fill[ch] + 1'b1;
        for (int i = 0; i < WINDOW_DEPTH; i++) begin
            if (i < hist_fill[ch] && speed_hist[ch][i] > peak)
                peak = speed_hist[ch][i];
        end
        return peak;
    endfunction

    // Advance the predicted state by one accepted tick and return the status
    // the block must answer with.
    function automatic t_resp predict_tick(input t_tick t);
        t_resp             r;
        logic [1:0]        mode;
        int                ch;
        logic [TIME_W-1:0] deadline;
        ch = int'(t.channel);
        r.out_channel = t.channel;
        if (ch >= CHANNELS) begin
            r.run_enabled   = 1'b0;
            r.running       = t.drive_ready;
            r.encoder_value = t.drive_command;
            return r;
        end
        mode = modes_shadow[2*ch +: 2];
        case (mode)
            MODE_ANALOG: begin
                if (!t.drive_ready) begin
                    // Losing readiness while running empties the history.
                    if (run_flag[ch]) begin
                        run_flag[ch]   = 1'b0;
                        stamp[ch]      = t.time_now;
                        held_value[ch] = '0;
                        hist_fill[ch]  = '0;
                        hist_head[ch]  = '0;
                    end
                end else if (!run_flag[ch]) begin
                    run_flag[ch]   = 1'b1;
                    stamp[ch]      = t.time_now;
                    change_cnt[ch] = '0;
                end else begin
                    // A zero change count means the start delay is still pending;
                    // any other count (also one left from pulse mode) means the
                    // sample period applies. The sums wrap at 32 bits.
                    deadline = stamp[ch] + ((change_cnt[ch] == 0) ? START_DELAY
                                                                   : TIME_W'(t.sample_time));
                    if (t.time_now >= deadline) begin
                        if (change_cnt[ch] == 0)
                            change_cnt[ch] = CNT_W'(1);
                        stamp[ch]      = t.time_now;
                        held_value[ch] = push_speed(ch, t.speed_sample);
                    end
                end
            end
            MODE_PULSE: begin
                if (!t.drive_ready) begin
                    if (change_cnt[ch] != 0) begin
                        change_cnt[ch] = '0;
                        run_flag[ch]   = 1'b0;
                        stamp[ch]      = t.time_now;
                        held_value[ch] = '0;
                    end
                end else begin
                    if (t.pulse_count != last_pulse[ch]) begin
                        last_pulse[ch] = t.pulse_count;
                        stamp[ch]      = t.time_now;
                        if (change_cnt[ch] < CHANGE_LIMIT)
                            change_cnt[ch] = change_cnt[ch] + 1'b1;
                        if (change_cnt[ch] >= CHANGE_LIMIT)
                            run_flag[ch] = 1'b1;
                    end else if (t.time_now < stamp[ch]) begin
                        // The seconds counter rolled over: restart the timer.
                        stamp[ch] = t.time_now;
                    end else begin
                        deadline = stamp[ch] + TIME_W'(t.sample_time);
                        if (run_flag[ch] && t.time_now >= deadline) begin
                            run_flag[ch]   = 1'b0;
                            change_cnt[ch] = '0;
                            stamp[ch]      = t.time_now;
                        end
                    end
                    held_value[ch] = run_flag[ch] ? t.drive_command : '0;
                end
            end
            default: begin
                // Disabled and pass-through channels follow the drive directly.
                run_flag[ch]   = t.drive_ready;
                held_value[ch] = t.drive_command;
            end
        endcase
        r.run_enabled   = (mode != MODE_DISABLED);
        r.running       = run_flag[ch];
        r.encoder_value = held_value[ch];
        return r;
    endfunction

    function automatic t_tick make_fixed(input logic [CH_W-1:0] ch, input logic [TIME_W-1:0] now,
                                         input logic ready, input logic [VAL_W-1:0] cmd,
                                         input logic [VAL_W-1:0] speed,
                                         input logic [PULSE_W-1:0] pulses,
                                         input logic [ST_W-1:0] st);
        t_tick t;
        t.channel       = ch;
        t.time_now      = now;
        t.drive_ready   = ready;
        t.drive_command = cmd;
        t.speed_sample  = speed;
        t.pulse_count   = pulses;
        t.sample_time   = st;
        return t;
    endfunction

    // Random tick. Most ticks follow a plausible drive: time moves forward by
    // up to two seconds, the drive is mostly ready, pulse counters mostly advance
    // and sample times are short. A share of ticks are pure noise. With focus
    // set, half of the ticks go to channels 0 and 1 so their windows fill up.
    function automatic t_tick make_tick(input int noise_pct, input bit focus);
        t_tick t;
        int    ch;
        ch = $urandom_range(0, CHANNELS - 1);
        if (focus && $urandom_range(0, 1) == 0)
            ch = $urandom_range(0, 1);
        clock_secs = clock_secs + $urandom_range(0, 2);
        case ($urandom_range(0, 5))
            0, 1:    ;
            2:       pulse_feed[ch] = $urandom;
            default: pulse_feed[ch] = pulse_feed[ch] + $urandom_range(1, 3);
        endcase
        t.channel       = CH_W'(ch);
        t.time_now      = clock_secs;
        t.drive_ready   = ($urandom_range(0, 15) != 0);
        t.drive_command = VAL_W'($urandom);
        t.speed_sample  = VAL_W'($urandom);
        t.pulse_count   = pulse_feed[ch];
        t.sample_time   = ST_W'($urandom_range(0, 6));
        if ($urandom_range(0, 99) < noise_pct) begin
            t.time_now    = $urandom;
            t.drive_ready = 1'($urandom);
            t.pulse_count = $urandom;
            t.sample_time = ST_W'($urandom);
        end
        return t;
    endfunction

    // Present one request and hold it until the block takes it. The predicted
    // status is queued at the accepting edge. Between bursts the sender drops
    // valid for a random number of cycles.
    task automatic send_tick(input t_tick t);
        req_bus.valid         <= 1'b1;
        req_bus.channel       <= t.channel;
        req_bus.time_now      <= t.time_now;
        req_bus.drive_ready   <= t.drive_ready;
        req_bus.drive_command <= t.drive_command;
        req_bus.speed_sample  <= t.speed_sample;
        req_bus.pulse_count   <= t.pulse_count;
        req_bus.sample_time   <= t.sample_time;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        expected_status_q.push_back(predict_tick(t));
        if (sender_idles) begin
            if (burst_left == 0) begin
                req_bus.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                burst_left = $urandom_range(1, 12);
            end else begin
                burst_left--;
            end
        end
    endtask

    // Stop sending and wait until every queued status has come back.
    task automatic drain();
        req_bus.valid <= 1'b0;
        @(posedge clk);
        while (expected_status_q.size() != 0)
            @(posedge clk);
    endtask

    // The mode register is only written while nothing is in flight; quiet
    // cycles waited out after the last response make sure the block is at rest.
    task automatic write_modes(input logic [MODES_W-1:0] value);
        drain();
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we       <= 1'b0;
        modes_shadow  = value;
    endtask

    task automatic run_random(input int count, input int noise_pct, input bit focus);
        for (int n = 0; n < count; n++)
            send_tick(make_tick(noise_pct, focus));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Pass-through on every channel with all fields at both extremes, then
    // every channel disabled, which must report run_enabled low.
    task automatic test_pass_and_disabled();
        write_modes({CHANNELS{MODE_PASS}});
        send_tick(make_fixed('1, '1, 1'b1, '1, '1, '1, '1));
        send_tick(make_fixed('0, '0, 1'b0, '0, '0, '0, '0));
        write_modes({CHANNELS{MODE_DISABLED}});
        send_tick(make_fixed(3'd3, 32'd40, 1'b1, 16'h1234, 16'h4321, 32'h5555_AAAA, 16'd9));
    endtask

    // Analog start, a first update that fires at once because the start-delay
    // sum wraps past the top of the seconds range, a period update, a zero
    // sample time, then loss of readiness clearing the window.
    task automatic test_analog_directed();
        write_modes({CHANNELS{MODE_ANALOG}});
        send_tick(make_fixed(3'd1, 32'hFFFF_FFFF, 1'b1, 16'd7, 16'h0100, '0, 16'd3));
        send_tick(make_fixed(3'd1, 32'hFFFF_FFFF, 1'b1, 16'd7, 16'h8000, '0, 16'd3));
        send_tick(make_fixed(3'd1, 32'd0, 1'b1, 16'd7, 16'hFFFF, '0, 16'd3));
        send_tick(make_fixed(3'd1, 32'd2, 1'b1, 16'd7, 16'hFFFF, '0, 16'd3));
        send_tick(make_fixed(3'd1, 32'd2, 1'b1, 16'd7, 16'h0000, '0, 16'd0));
        send_tick(make_fixed(3'd1, 32'd3, 1'b0, 16'd7, 16'h0055, '0, 16'd0));
        send_tick(make_fixed(3'd1, 32'd4, 1'b0, 16'd7, 16'h0055, '0, 16'd0));
    endtask

    // Three pulse changes set running, a time rollover only restarts the
    // timer, a quiet sample period clears running, and losing readiness
    // clears a partial change count.
    task automatic test_pulse_directed();
        write_modes({CHANNELS{MODE_PULSE}});
        send_tick(make_fixed(3'd5, 32'd10, 1'b1, 16'hABCD, '0, 32'd1, 16'd4));
        send_tick(make_fixed(3'd5, 32'd11, 1'b1, 16'hABCD, '0, 32'd2, 16'd4));
        send_tick(make_fixed(3'd5, 32'd12, 1'b1, 16'hABCD, '0, 32'd3, 16'd4));
        send_tick(make_fixed(3'd5, 32'd5, 1'b1, 16'h1357, '0, 32'd3, 16'd4));
        send_tick(make_fixed(3'd5, 32'd20, 1'b1, 16'h1357, '0, 32'd3, 16'd4));
        send_tick(make_fixed(3'd5, 32'd21, 1'b1, 16'h2468, '0, 32'hFFFF_FFFF, 16'd4));
        send_tick(make_fixed(3'd5, 32'd22, 1'b0, 16'h2468, '0, 32'hFFFF_FFFF, 16'd4));
    endtask

    // All channels analog: first a stretch without any idling, then with
    // sender gaps and receiver stalls.
    task automatic test_random_analog();
        write_modes({CHANNELS{MODE_ANALOG}});
        clock_secs      = $urandom_range(0, 1000);
        sender_idles    = 1'b0;
        receiver_stalls = 1'b0;
        run_random(60, 5, 1'b1);
        sender_idles    = 1'b1;
        receiver_stalls = 1'b1;
        run_random(160, 5, 1'b1);
    endtask

    // All channels pulse counted. Halfway the sender holds off until every
    // outstanding request has been answered.
    task automatic test_random_pulse();
        write_modes({CHANNELS{MODE_PULSE}});
        run_random(110, 5, 1'b1);
        drain();
        run_random(110, 5, 1'b1);
    endtask

    // Random mode maps over channels that carry state from earlier modes.
    // One phase starts just below the top of the seconds range so that the
    // clock may roll over in the middle of it.
    task automatic test_random_mixed();
        for (int phase = 0; phase < 5; phase++) begin
            if (phase == 2) begin
                write_modes(16'hE4E4);
                clock_secs = 32'hFFFF_FF80;
            end else begin
                write_modes(MODES_W'($urandom_range(0, 65535)));
            end
            sender_idles    = ($urandom_range(0, 3) != 0);
            receiver_stalls = ($urandom_range(0, 3) != 0);
            run_random(90, 10, phase[0]);
        end
    endtask

    // ------------------------------------------------------------------
    // Response checking. Every accepted status is compared against the
    // oldest prediction; sampling happens at the clock edge, so the values
    // seen are the ones the handshake completed with.
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk) begin : check_responses
        t_resp want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (expected_status_q.size() == 0) begin
                $error("response for channel %0d with no request outstanding",
                       rsp_bus.out_channel);
                mismatches++;
            end else begin
                want = expected_status_q.pop_front();
                check_field("out_channel", 32'(want.out_channel),
                            32'(rsp_bus.out_channel));
                check_field("run_enabled", 32'(want.run_enabled),
                            32'(rsp_bus.run_enabled));
                check_field("running", 32'(want.running), 32'(rsp_bus.running));
                check_field("encoder_value", 32'(want.encoder_value),
                            32'(rsp_bus.encoder_value));
            end
        end
        // The stall pattern rotates and is reloaded whenever the step counter wraps:
        // sometimes solid ready, sometimes random, mostly lightly stalled.
        stall_step <= stall_step + 1'b1;
        if (stall_step == 0) begin
            case ($urandom_range(0, 3))
                0:       stall_pattern <= '1;
                1:       stall_pattern <= $urandom;
                default: stall_pattern <= $urandom | $urandom;
            endcase
        end else begin
            stall_pattern <= {stall_pattern[0], stall_pattern[31:1]};
        end
        rsp_bus.ready <= receiver_stalls ? stall_pattern[0] : 1'b1;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        req_bus.valid         = 1'b0;
        req_bus.channel       = '0;
        req_bus.time_now      = '0;
        req_bus.drive_ready   = 1'b0;
        req_bus.drive_command = '0;
        req_bus.speed_sample  = '0;
        req_bus.pulse_count   = '0;
        req_bus.sample_time   = '0;
        rsp_bus.ready         = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The directed part runs with light idling on both sides.
        sender_idles    = 1'b1;
        receiver_stalls = 1'b1;
        test_pass_and_disabled();
        test_analog_directed();
        test_pulse_directed();
        test_random_analog();
        test_random_pulse();
        test_random_mixed();

        // Wait for the last responses, then give the block time to show any
        // response it should not produce.
        drain();
        repeat (40) @(posedge clk);
        if (mismatches == 0 && expected_status_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== drive_run_detector.f =====
design/drd_pkg.sv
design/drd_if.sv
design/drd_ctrl.sv
design/drd_dpath.sv
design/drive_run_detector.sv
tb/testbench.sv
